// ----- rtl/core/pdbe_pkg.sv -----
// ----------------------------------------------------------------------------
// pdbe_pkg
// Shared constants, codes and base-code helpers of the polyline delta encoder.
// ----------------------------------------------------------------------------
package pdbe_pkg;

    // default sizes
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    // fixed result widths
    localparam int CODE_W   = 24;
    localparam int CWIDTH_W = 5;
    localparam int WORD_W   = 32;

    // base code mapping
    localparam logic [4:0] BASE_SPLIT = 5'd10;
    localparam logic [4:0] BASE_KNEE  = 5'd9;
    localparam logic [4:0] BASE_MAX   = 5'd15;
    localparam logic [4:0] BASE_OFS   = 5'd2;
    localparam logic [4:0] HDR_WIDTH  = 5'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_EXTRA_BITS   = 3'd0;
    localparam logic [2:0] CFG_COUNT_NUMBER = 3'd1;
    localparam logic [2:0] CFG_EXTENDED     = 3'd2;
    localparam logic [2:0] CFG_LAST_SEGMENT = 3'd3;
    localparam logic [2:0] CFG_CLOSED       = 3'd4;
    localparam logic [2:0] CFG_MIN_POINTS   = 3'd5;

    // result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_POINT  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BASE     = 2'd1;
    localparam logic [1:0] ST_FEW      = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // map a bit length to its 4-bit base code (may exceed 15)
    function automatic logic [4:0] to_base(input logic [5:0] bits);
        logic [5:0] b;
        b = (bits > 6'd2) ? (bits - 6'd2) : 6'd0;
        if (b > {1'b0, BASE_SPLIT})
        begin
            if (!b[0])
            begin
                b = b + 6'd1;
            end
            b = {1'b0, BASE_KNEE} + ((b - {1'b0, BASE_KNEE}) >> 1);
        end
        return b[4:0];
    endfunction

    // bit count written for a base code
    function automatic logic [4:0] from_base(input logic [4:0] b);
        logic [5:0] w;
        if (b < BASE_SPLIT)
        begin
            w = {1'b0, b} + {1'b0, BASE_OFS};
        end
        else
        begin
            w = {b, 1'b0} - 6'd7;
        end
        return w[4:0];
    endfunction

endpackage

// ----- rtl/core/pdbe_alu.sv -----
// ----------------------------------------------------------------------------
// pdbe_alu
// Shared delta unit: subtracts two coordinates and folds the difference into
// a running minimum and maximum. Used for x, then y, of every point that adds a delta.
// ----------------------------------------------------------------------------
module pdbe_alu #(
    parameter int COORD_BITS = 24
) (
    input  logic signed [COORD_BITS-1:0] cur,
    input  logic signed [COORD_BITS-1:0] prev,
    input  logic signed [COORD_BITS:0]   min_in,
    input  logic signed [COORD_BITS:0]   max_in,
    output logic signed [COORD_BITS:0]   diff,
    output logic signed [COORD_BITS:0]   min_out,
    output logic signed [COORD_BITS:0]   max_out
);

    // difference at one bit of growth
    assign diff = {cur[COORD_BITS-1], cur} - {prev[COORD_BITS-1], prev};

    // fold into extremes
    assign min_out = (diff < min_in) ? diff : min_in;
    assign max_out = (diff > max_in) ? diff : max_in;

endmodule

// ----- rtl/core/pdbe_store.sv -----
// ----------------------------------------------------------------------------
// pdbe_store
// Delta store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pdbe_store #(
    parameter int DEPTH  = 64,
    parameter int WORD_W = 51
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WORD_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WORD_W-1:0]        rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    // write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/polyline_delta_bit_encoder_top.sv -----
// ----------------------------------------------------------------------------
// polyline_delta_bit_encoder_top
// Stores the deltas of one polyline and emits its header and point codes.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low. Each point keeps busy
// high through S_LOAD_X and S_LOAD_Y (S_LOAD_X only for the first, a dropped
// or an overflowing point), since one shared subtract and min/max unit works
// x and then y. On the point marked last the block measures both axes with a
// one-bit-per-cycle shifter, scans the stored deltas once to settle which
// are kept, then emits the header and, unless the header reports an error
// status or no delta is kept, one item per kept delta, one item per cycle at
// best, paced by the single read port of the delta store. Each result shows
// for exactly one cycle with strobe high; the receiver cannot stall it. busy
// stays high until the final result of the polyline is out.
// ----------------------------------------------------------------------------
module polyline_delta_bit_encoder_top
    import pdbe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // point channel
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  lat,
    input  logic signed [COORD_BITS-1:0]  lon,
    input  logic                          routing_node,
    input  logic                          number_node,
    input  logic                          last,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [6:0]                    cfg_data,
    // result channel
    output logic                          strobe,
    output logic                          kind,
    output logic [CODE_W-1:0]             x_code,
    output logic [CWIDTH_W-1:0]           x_width,
    output logic [CODE_W-1:0]             y_code,
    output logic [CWIDTH_W-1:0]           y_width,
    output logic [3:0]                    flag_bits,
    output logic [2:0]                    flag_count,
    output logic                          end_of_run,
    output logic [1:0]                    status
);

    localparam int DW  = COORD_BITS + 1;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int LW  = $clog2(DW + 1);
    localparam int MW  = 2 * DW + 1;
    localparam logic signed [DW-1:0] MIN_RESET = DW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [PCW-1:0] PC_MAX = PCW'(MAX_POINTS);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOAD_X  = 3'd1;
    localparam logic [2:0] S_LOAD_Y  = 3'd2;
    localparam logic [2:0] S_MEASURE = 3'd3;
    localparam logic [2:0] S_COUNT   = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;
    localparam logic [2:0] S_HEADER  = 3'd6;
    localparam logic [2:0] S_EMIT    = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration
    logic       extra_reg, count_num_reg, ext_type_reg, last_seg_reg, closed_reg;
    logic [6:0] min_pts_reg;

    // latched point
    logic signed [COORD_BITS-1:0] pt_lat_reg, pt_lon_reg, pt_lat_next, pt_lon_next;
    logic pt_special_reg, pt_special_next, pt_last_reg, pt_last_next;

    // run state
    logic [PCW-1:0] pc_reg, pc_next;
    logic signed [COORD_BITS-1:0] prev_lat_reg, prev_lat_next, prev_lon_reg, prev_lon_next;
    logic signed [COORD_BITS-1:0] first_lat_reg, first_lat_next;
    logic signed [COORD_BITS-1:0] first_lon_reg, first_lon_next;
    logic signed [DW-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic signed [DW-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic signed [DW-1:0] dx_hold_reg, dx_hold_next;
    logic ovf_reg, ovf_next;

    // measurement
    logic [DW-1:0] mag_reg, mag_next;
    logic [LW-1:0] len_reg, len_next, xbl_reg, xbl_next, ybl_reg, ybl_next;
    logic          axis_reg, axis_next;

    // scan / emit
    logic [PCW-1:0] iss_reg, iss_next, enc_reg, enc_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  pidx_reg, pidx_next, lk_reg, lk_next;
    logic           any_reg, any_next;

    // outputs
    logic                strobe_reg, strobe_next, kind_reg, kind_next;
    logic [CODE_W-1:0]   xc_reg, xc_next, yc_reg, yc_next;
    logic [CWIDTH_W-1:0] xw_reg, xw_next, yw_reg, yw_next;
    logic [3:0]          fb_reg, fb_next;
    logic [2:0]          fc_reg, fc_next;
    logic                eor_reg, eor_next;
    logic [1:0]          st_reg, st_next;

    // shared unit
    logic signed [COORD_BITS-1:0] alu_cur, alu_prev;
    logic signed [DW-1:0] alu_min_in, alu_max_in, alu_diff, alu_min_out, alu_max_out;

    // store
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata, mem_rdata;

    // pick the axis for the shared unit
    always_comb
    begin
        if (state_reg == S_LOAD_Y)
        begin
            alu_cur    = pt_lat_reg;
            alu_prev   = prev_lat_reg;
            alu_min_in = min_y_reg;
            alu_max_in = max_y_reg;
        end
        else
        begin
            alu_cur    = pt_lon_reg;
            alu_prev   = prev_lon_reg;
            alu_min_in = min_x_reg;
            alu_max_in = max_x_reg;
        end
    end

    pdbe_alu #(
        .COORD_BITS(COORD_BITS)
    ) u_alu (
        .cur    (alu_cur),
        .prev   (alu_prev),
        .min_in (alu_min_in),
        .max_in (alu_max_in),
        .diff   (alu_diff),
        .min_out(alu_min_out),
        .max_out(alu_max_out)
    );

    pdbe_store #(
        .DEPTH (MAX_POINTS),
        .WORD_W(MW)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // axis summaries
    logic          x_same, y_same, x_neg, y_neg;
    logic [4:0]    x_base, y_base, x_wd, y_wd;
    logic [DW-1:0] abs_min;
    logic          hdr_bad;
    logic [1:0]    hdr_st;
    logic [3:0]    hdr_fb;
    logic [2:0]    hdr_fc;
    logic [2:0]    fpos;
    logic [PCW-1:0] n_deltas;

    assign x_neg  = min_x_reg[DW-1];
    assign y_neg  = min_y_reg[DW-1];
    assign x_same = !(x_neg && (max_x_reg > 0));
    assign y_same = !(y_neg && (max_y_reg > 0));
    assign x_base = to_base(6'(xbl_reg));
    assign y_base = to_base(6'(ybl_reg));
    assign x_wd   = from_base(x_base) + {4'd0, !x_same};
    assign y_wd   = from_base(y_base) + {4'd0, !y_same};
    assign n_deltas = (pc_reg != '0) ? (pc_reg - PCW'(1)) : '0;

    // magnitude of a minimum (maximum is never negative)
    always_comb
    begin
        logic signed [DW-1:0] m;
        m = (state_reg == S_MEASURE) ? min_x_reg : min_y_reg;
        abs_min = m[DW-1] ? DW'(-m) : DW'(m);
    end

    // header flags and status
    always_comb
    begin
        hdr_fb = '0;
        fpos   = 3'd0;
        hdr_fb[fpos[1:0]] = x_same;
        fpos = fpos + 3'd1;
        if (x_same)
        begin
            hdr_fb[fpos[1:0]] = x_neg;
            fpos = fpos + 3'd1;
        end
        hdr_fb[fpos[1:0]] = y_same;
        fpos = fpos + 3'd1;
        if (y_same)
        begin
            hdr_fb[fpos[1:0]] = y_neg;
            fpos = fpos + 3'd1;
        end
        hdr_fc = fpos + {2'd0, ext_type_reg} + {2'd0, extra_reg};
        if (ovf_reg)
        begin
            hdr_st = ST_OVERFLOW;
        end
        else if ((x_base > BASE_MAX) || (y_base > BASE_MAX))
        begin
            hdr_st = ST_BASE;
        end
        else if ({1'b0, 7'(enc_reg)} < {1'b0, min_pts_reg})
        begin
            hdr_st = ST_FEW;
        end
        else
        begin
            hdr_st = ST_OK;
        end
        hdr_bad = (hdr_st != ST_OK) || !any_reg;
    end

    // evaluate the entry coming out of the store
    logic signed [DW-1:0] e_dx, e_dy;
    logic                 e_nm, e_nbit, e_keep, e_inner;
    logic [DW-1:0]        e_xv, e_yv;
    logic [WORD_W-1:0]    e_xe, e_ye;

    always_comb
    begin
        e_dx    = mem_rdata[DW-1:0];
        e_dy    = mem_rdata[2*DW-1:DW];
        e_nm    = mem_rdata[2*DW];
        e_inner = ({1'b0, pidx_reg} + (AW+1)'(2)) < (AW+1)'(pc_reg);
        e_nbit  = extra_reg && e_nm && (e_inner || !last_seg_reg);
        e_keep  = !((e_dx == 0) && (e_dy == 0) && extra_reg && !e_nbit &&
                    (({1'b0, pidx_reg} + (AW+1)'(2)) != (AW+1)'(pc_reg)));
        e_xv = (x_same && e_dx[DW-1]) ? DW'(-e_dx) : DW'(e_dx);
        e_yv = (y_same && e_dy[DW-1]) ? DW'(-e_dy) : DW'(e_dy);
        e_xe = {{(WORD_W-DW){e_xv[DW-1]}}, e_xv} & ~({WORD_W{1'b1}} << x_wd);
        e_ye = {{(WORD_W-DW){e_yv[DW-1]}}, e_yv} & ~({WORD_W{1'b1}} << y_wd);
    end

    // sequencer
    always_comb
    begin
        logic use_pt;
        state_next      = state_reg;
        pt_lat_next     = pt_lat_reg;
        pt_lon_next     = pt_lon_reg;
        pt_special_next = pt_special_reg;
        pt_last_next    = pt_last_reg;
        pc_next         = pc_reg;
        prev_lat_next   = prev_lat_reg;
        prev_lon_next   = prev_lon_reg;
        first_lat_next  = first_lat_reg;
        first_lon_next  = first_lon_reg;
        min_x_next      = min_x_reg;
        max_x_next      = max_x_reg;
        min_y_next      = min_y_reg;
        max_y_next      = max_y_reg;
        dx_hold_next    = dx_hold_reg;
        ovf_next        = ovf_reg;
        mag_next        = mag_reg;
        len_next        = len_reg;
        xbl_next        = xbl_reg;
        ybl_next        = ybl_reg;
        axis_next       = axis_reg;
        iss_next        = iss_reg;
        enc_next        = enc_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        lk_next         = lk_reg;
        any_next        = any_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        xc_next         = xc_reg;
        yc_next         = yc_reg;
        xw_next         = xw_reg;
        yw_next         = yw_reg;
        fb_next         = fb_reg;
        fc_next         = fc_reg;
        eor_next        = eor_reg;
        st_next         = st_reg;
        mem_we          = 1'b0;
        mem_waddr       = AW'(pc_reg - PCW'(1));
        mem_wdata       = {pt_special_reg, alu_diff, dx_hold_reg};
        mem_re          = 1'b0;
        mem_raddr       = iss_reg[AW-1:0];
        use_pt          = !(pt_last_reg && closed_reg && (pc_reg != '0) &&
                            (pt_lat_reg == first_lat_reg) && (pt_lon_reg == first_lon_reg));

        case (state_reg)
            S_IDLE:
            begin
                // take a point
                if (start)
                begin
                    pt_lat_next     = lat;
                    pt_lon_next     = lon;
                    pt_special_next = routing_node || (count_num_reg && number_node);
                    pt_last_next    = last;
                    state_next      = S_LOAD_X;
                end
            end
            S_LOAD_X:
            begin
                // drop, overflow, first point, or x delta
                state_next = pt_last_reg ? S_MEASURE : S_IDLE;
                if (use_pt)
                begin
                    if (pc_reg >= PC_MAX)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (pc_reg == '0)
                    begin
                        first_lat_next = pt_lat_reg;
                        first_lon_next = pt_lon_reg;
                        prev_lat_next  = pt_lat_reg;
                        prev_lon_next  = pt_lon_reg;
                        pc_next        = PCW'(1);
                    end
                    else
                    begin
                        dx_hold_next = alu_diff;
                        min_x_next   = alu_min_out;
                        max_x_next   = alu_max_out;
                        state_next   = S_LOAD_Y;
                    end
                end
            end
            S_LOAD_Y:
            begin
                // y delta, store the pair with the node mark
                min_y_next    = alu_min_out;
                max_y_next    = alu_max_out;
                mem_we        = 1'b1;
                prev_lat_next = pt_lat_reg;
                prev_lon_next = pt_lon_reg;
                pc_next       = pc_reg + PCW'(1);
                state_next    = pt_last_reg ? S_MEASURE : S_IDLE;
            end
            S_MEASURE:
            begin
                // load x magnitude
                mag_next   = abs_min | max_x_reg;
                len_next   = '0;
                axis_next  = 1'b0;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                // shift out one bit a cycle
                if (mag_reg != '0)
                begin
                    mag_next = mag_reg >> 1;
                    len_next = len_reg + LW'(1);
                end
                else if (!axis_reg)
                begin
                    xbl_next  = len_reg;
                    mag_next  = abs_min | max_y_reg;
                    len_next  = '0;
                    axis_next = 1'b1;
                end
                else
                begin
                    ybl_next   = len_reg;
                    iss_next   = '0;
                    enc_next   = PCW'(1);
                    any_next   = 1'b0;
                    lk_next    = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue reads, count kept deltas
                if (iss_reg < n_deltas)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + PCW'(1);
                end
                if (pend_reg && e_keep)
                begin
                    enc_next = enc_reg + PCW'(1);
                    lk_next  = pidx_reg;
                    any_next = 1'b1;
                end
                if (!(iss_reg < n_deltas) && !pend_reg)
                begin
                    state_next = S_HEADER;
                end
            end
            S_HEADER:
            begin
                // give the header item
                strobe_next = 1'b1;
                kind_next   = KIND_HEADER;
                xc_next     = CODE_W'(x_base);
                yc_next     = CODE_W'(y_base);
                xw_next     = HDR_WIDTH;
                yw_next     = HDR_WIDTH;
                fb_next     = hdr_fb;
                fc_next     = hdr_fc;
                eor_next    = hdr_bad;
                st_next     = hdr_st;
                iss_next    = '0;
                state_next  = hdr_bad ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                // read again, give each kept delta
                if (iss_reg < n_deltas)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + PCW'(1);
                end
                if (pend_reg && e_keep)
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_POINT;
                    xc_next     = e_xe[CODE_W-1:0];
                    yc_next     = e_ye[CODE_W-1:0];
                    xw_next     = x_wd;
                    yw_next     = y_wd;
                    fb_next     = {3'd0, e_nbit};
                    fc_next     = {2'd0, extra_reg};
                    eor_next    = (pidx_reg == lk_reg);
                    st_next     = ST_OK;
                end
                if (!(iss_reg < n_deltas) && !pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // clear the run once its last item is out
        if (((state_reg == S_HEADER) && hdr_bad) ||
            ((state_reg == S_EMIT) && !(iss_reg < n_deltas) && !pend_reg))
        begin
            pc_next        = '0;
            prev_lat_next  = '0;
            prev_lon_next  = '0;
            first_lat_next = '0;
            first_lon_next = '0;
            min_x_next     = MIN_RESET;
            min_y_next     = MIN_RESET;
            max_x_next     = '0;
            max_y_next     = '0;
            ovf_next       = 1'b0;
        end
    end

    // control and run registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            first_lat_reg <= '0;
            first_lon_reg <= '0;
            min_x_reg     <= MIN_RESET;
            min_y_reg     <= MIN_RESET;
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            axis_reg      <= 1'b0;
            any_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            prev_lat_reg  <= prev_lat_next;
            prev_lon_reg  <= prev_lon_next;
            first_lat_reg <= first_lat_next;
            first_lon_reg <= first_lon_next;
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            strobe_reg    <= strobe_next;
            axis_reg      <= axis_next;
            any_reg       <= any_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pt_lat_reg     <= pt_lat_next;
        pt_lon_reg     <= pt_lon_next;
        pt_special_reg <= pt_special_next;
        pt_last_reg    <= pt_last_next;
        dx_hold_reg    <= dx_hold_next;
        mag_reg        <= mag_next;
        len_reg        <= len_next;
        xbl_reg        <= xbl_next;
        ybl_reg        <= ybl_next;
        iss_reg        <= iss_next;
        enc_reg        <= enc_next;
        pidx_reg       <= pidx_next;
        lk_reg         <= lk_next;
        kind_reg       <= kind_next;
        xc_reg         <= xc_next;
        yc_reg         <= yc_next;
        xw_reg         <= xw_next;
        yw_reg         <= yw_next;
        fb_reg         <= fb_next;
        fc_reg         <= fc_next;
        eor_reg        <= eor_next;
        st_reg         <= st_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg     <= 1'b0;
            count_num_reg <= 1'b0;
            ext_type_reg  <= 1'b0;
            last_seg_reg  <= 1'b1;
            closed_reg    <= 1'b0;
            min_pts_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_EXTRA_BITS:   extra_reg     <= cfg_data[0];
                CFG_COUNT_NUMBER: count_num_reg <= cfg_data[0];
                CFG_EXTENDED:     ext_type_reg  <= cfg_data[0];
                CFG_LAST_SEGMENT: last_seg_reg  <= cfg_data[0];
                CFG_CLOSED:       closed_reg    <= cfg_data[0];
                CFG_MIN_POINTS:   min_pts_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign x_code     = xc_reg;
    assign x_width    = xw_reg;
    assign y_code     = yc_reg;
    assign y_width    = yw_reg;
    assign flag_bits  = fb_reg;
    assign flag_count = fc_reg;
    assign end_of_run = eor_reg;
    assign status     = st_reg;

    // checks
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !pend_reg)
        else $error("read pending while idle");

    a_eor_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && end_of_run |=> !strobe)
        else $error("item right after end of run");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_MAX)
        else $error("point count beyond store");

    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ST_OK) |-> end_of_run && (kind == KIND_HEADER))
        else $error("error status not on a final header");

endmodule
